// File: rtl/tlo_pkg.sv
// Package for the table lookup oscillator: widths, codes, item and config types,
// and the table length clamp functions. No dependencies.
package tlo_pkg;

   // Table geometry and phase format
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int PHASE_FRAC  = 20;
   localparam int PHASE_W     = ADDR_W + PHASE_FRAC;
   localparam int LIM_W       = PHASE_W + 1;

   // Field widths
   localparam int IDX_W     = 12;
   localparam int WORD_W    = 24;
   localparam int WORD_FRAC = 23;
   localparam int AMP_W     = 32;
   localparam int FREQ_W    = 32;
   localparam int SCALE_W   = 32;
   localparam int LEN_W     = 13;
   localparam int SAMPLE_W  = 32;

   // Datapath widths
   localparam int PROD_W     = FREQ_W + SCALE_W;
   localparam int MAG_W      = PROD_W - PHASE_FRAC;
   localparam int SPROD_W    = AMP_W + WORD_W;
   localparam int SHIFTED_W  = SPROD_W - WORD_FRAC;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Config port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LENGTH = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_SCALE   = 4'd1;

   localparam logic [LEN_W-1:0]   RESET_TABLE_LENGTH = 13'd4096;
   localparam logic [SCALE_W-1:0] RESET_FREQ_SCALE   = 32'd1431656;

   // Request codes
   localparam logic REQ_WRITE    = 1'b0;
   localparam logic REQ_GENERATE = 1'b1;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                      gen;
      logic [IDX_W-1:0]          index;
      logic signed [WORD_W-1:0]  value;
      logic signed [AMP_W-1:0]   amp;
      logic                      neg;
      logic [PHASE_W-1:0]        mag;
   } tlo_item_type;

   typedef struct packed {
      logic [LIM_W-1:0]   limit;
      logic [PHASE_W-1:0] limit_m1;
      logic [SCALE_W-1:0] freq_scale;
   } tlo_cfg_type;

   // Effective length (0 acts as 1, clamp to depth) in phase units
   function automatic logic [LIM_W-1:0] eff_limit(input logic [LEN_W-1:0] len);
      logic [31:0] n;
      n = 32'(len);
      if (n == 32'd0) n = 32'd1;
      if (n > 32'(TABLE_DEPTH)) n = 32'(TABLE_DEPTH);
      return LIM_W'(n) << PHASE_FRAC;
   endfunction

   function automatic logic [PHASE_W-1:0] eff_limit_m1(input logic [LEN_W-1:0] len);
      logic [LIM_W-1:0] lm1;
      lm1 = eff_limit(len) - LIM_W'(1);
      return lm1[PHASE_W-1:0];
   endfunction

endpackage

// File: rtl/table_lookup_oscillator.sv
// Truncating wavetable oscillator, top level.
// Path: front registers, queue, table read, product register, output register.
// One item per cycle unless output stalls; phase add and wrap are combinational.
// A 4-entry queue lets the front keep accepting items during short output stalls.
// Reset (synchronous): phase 0, table_length 4096, freq_scale 1431656; the wave
// table is not cleared and holds garbage until written.
module table_lookup_oscillator (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [tlo_pkg::IDX_W-1:0]           req_table_index,
   input  logic signed [tlo_pkg::WORD_W-1:0]   req_table_value,
   input  logic signed [tlo_pkg::AMP_W-1:0]    req_amplitude,
   input  logic signed [tlo_pkg::FREQ_W-1:0]   req_frequency,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tlo_pkg::SAMPLE_W-1:0] rsp_sample,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tlo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tlo_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tlo_pkg::*;

   // Config registers. Table length is stored already clamped and in phase
   // units (limit) plus limit-1, so the datapath never re-derives them.
   logic [LIM_W-1:0]   limit_ff, limit_in;
   logic [PHASE_W-1:0] limit_m1_ff, limit_m1_in;
   logic [SCALE_W-1:0] freq_scale_ff, freq_scale_in;
   tlo_cfg_type        cfg;

   // front -> queue -> back
   logic               fq_valid;
   logic               fq_ready;
   tlo_item_type       fq_item;
   logic               qb_valid;
   logic               qb_ready;
   tlo_item_type       qb_item;
   logic [SAMPLE_W-1:0] sample;

   // Config writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      limit_in      = limit_ff;
      limit_m1_in   = limit_m1_ff;
      freq_scale_in = freq_scale_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TABLE_LENGTH: begin
               limit_in    = eff_limit(csr_data[LEN_W-1:0]);
               limit_m1_in = eff_limit_m1(csr_data[LEN_W-1:0]);
            end
            CSR_FREQ_SCALE: begin
               freq_scale_in = csr_data[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= eff_limit(RESET_TABLE_LENGTH);
         limit_m1_ff   <= eff_limit_m1(RESET_TABLE_LENGTH);
         freq_scale_ff <= RESET_FREQ_SCALE;
      end else begin
         limit_ff      <= limit_in;
         limit_m1_ff   <= limit_m1_in;
         freq_scale_ff <= freq_scale_in;
      end
   end

   assign cfg.limit      = limit_ff;
   assign cfg.limit_m1   = limit_m1_ff;
   assign cfg.freq_scale = freq_scale_ff;

   // Front: input register, |f| * scale, increment clamp.
   tlo_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_amplitude   (req_amplitude),
      .req_frequency   (req_frequency),
      .out_valid       (fq_valid),
      .out_ready       (fq_ready),
      .out_item        (fq_item)
   );

   // Decoupling queue between the two halves.
   tlo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   // Back: table write or phase step + lookup, scale, saturate, output register.
   tlo_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (qb_valid),
      .in_ready   (qb_ready),
      .in_item    (qb_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (sample)
   );

   assign rsp_sample = $signed(sample);

endmodule

// File: rtl/tlo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlo_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/tlo_front.sv
// Front end: accepts items, classifies them, forms the clamped phase increment.
// Depends on tlo_pkg.
module tlo_front (
   input  logic                                clock,
   input  logic                                reset,
   input  tlo_pkg::tlo_cfg_type                cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [tlo_pkg::IDX_W-1:0]           req_table_index,
   input  logic signed [tlo_pkg::WORD_W-1:0]   req_table_value,
   input  logic signed [tlo_pkg::AMP_W-1:0]    req_amplitude,
   input  logic signed [tlo_pkg::FREQ_W-1:0]   req_frequency,
   output logic                                out_valid,
   input  logic                                out_ready,
   output tlo_pkg::tlo_item_type               out_item
);
   import tlo_pkg::*;

   logic                     adv;
   logic                     accept;
   logic                     freq_neg;
   logic [FREQ_W-1:0]        freq_u;
   logic [FREQ_W-1:0]        freq_abs;
   logic [MAG_W-1:0]         mag_full;

   // stage 1: registered item with |frequency|
   logic                     f1_valid_ff, f1_valid_in;
   logic                     f1_gen_ff, f1_gen_in;
   logic [IDX_W-1:0]         f1_index_ff, f1_index_in;
   logic signed [WORD_W-1:0] f1_value_ff, f1_value_in;
   logic signed [AMP_W-1:0]  f1_amp_ff, f1_amp_in;
   logic                     f1_neg_ff, f1_neg_in;
   logic [FREQ_W-1:0]        f1_fabs_ff, f1_fabs_in;

   // stage 2: |frequency| * freq_scale
   logic                     f2_valid_ff, f2_valid_in;
   logic                     f2_gen_ff, f2_gen_in;
   logic [IDX_W-1:0]         f2_index_ff, f2_index_in;
   logic signed [WORD_W-1:0] f2_value_ff, f2_value_in;
   logic signed [AMP_W-1:0]  f2_amp_ff, f2_amp_in;
   logic                     f2_neg_ff, f2_neg_in;
   logic [PROD_W-1:0]        f2_prod_ff, f2_prod_in;

   assign adv       = !f2_valid_ff || out_ready;
   assign req_ready = !f1_valid_ff || adv;
   assign accept    = req_valid && req_ready;

   assign freq_u   = $unsigned(req_frequency);
   assign freq_neg = req_frequency[FREQ_W-1];
   assign freq_abs = freq_neg ? (~freq_u + 1'b1) : freq_u;

   always_comb begin
      f1_valid_in = f1_valid_ff;
      f1_gen_in   = f1_gen_ff;
      f1_index_in = f1_index_ff;
      f1_value_in = f1_value_ff;
      f1_amp_in   = f1_amp_ff;
      f1_neg_in   = f1_neg_ff;
      f1_fabs_in  = f1_fabs_ff;
      if (adv) begin
         f1_valid_in = 1'b0;
      end
      if (accept) begin
         f1_valid_in = 1'b1;
         f1_gen_in   = (req_type == REQ_GENERATE);
         f1_index_in = req_table_index;
         f1_value_in = req_table_value;
         f1_amp_in   = req_amplitude;
         f1_neg_in   = freq_neg;
         f1_fabs_in  = freq_abs;
      end
   end

   always_comb begin
      f2_valid_in = f2_valid_ff;
      f2_gen_in   = f2_gen_ff;
      f2_index_in = f2_index_ff;
      f2_value_in = f2_value_ff;
      f2_amp_in   = f2_amp_ff;
      f2_neg_in   = f2_neg_ff;
      f2_prod_in  = f2_prod_ff;
      if (adv) begin
         f2_valid_in = f1_valid_ff;
         f2_gen_in   = f1_gen_ff;
         f2_index_in = f1_index_ff;
         f2_value_in = f1_value_ff;
         f2_amp_in   = f1_amp_ff;
         f2_neg_in   = f1_neg_ff;
         f2_prod_in  = PROD_W'(f1_fabs_ff) * PROD_W'(cfg.freq_scale);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_gen_ff   <= f1_gen_in;
      f1_index_ff <= f1_index_in;
      f1_value_ff <= f1_value_in;
      f1_amp_ff   <= f1_amp_in;
      f1_neg_ff   <= f1_neg_in;
      f1_fabs_ff  <= f1_fabs_in;
      f2_gen_ff   <= f2_gen_in;
      f2_index_ff <= f2_index_in;
      f2_value_ff <= f2_value_in;
      f2_amp_ff   <= f2_amp_in;
      f2_neg_ff   <= f2_neg_in;
      f2_prod_ff  <= f2_prod_in;
   end

   // increment to phase format, limited just below the table length
   assign mag_full = f2_prod_ff[PROD_W-1:PHASE_FRAC];

   always_comb begin
      out_item.gen   = f2_gen_ff;
      out_item.index = f2_index_ff;
      out_item.value = f2_value_ff;
      out_item.amp   = f2_amp_ff;
      out_item.neg   = f2_neg_ff;
      if (mag_full > MAG_W'(cfg.limit_m1)) begin
         out_item.mag = cfg.limit_m1;
      end else begin
         out_item.mag = mag_full[PHASE_W-1:0];
      end
   end

   assign out_valid = f2_valid_ff;

endmodule

// File: rtl/tlo_queue.sv
// Short FIFO of decoded items between front and back end.
// Depends on tlo_pkg.
module tlo_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  tlo_pkg::tlo_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output tlo_pkg::tlo_item_type pop_item
);
   import tlo_pkg::*;

   tlo_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/tlo_back.sv
// Back end: table writes, phase accumulator, lookup, scaling and output register.
// Depends on tlo_pkg and tlo_ram.
module tlo_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tlo_pkg::tlo_cfg_type          cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  tlo_pkg::tlo_item_type         in_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tlo_pkg::SAMPLE_W-1:0]  rsp_sample
);
   import tlo_pkg::*;

   logic                      back_adv;
   logic                      pop;
   logic                      pop_gen;
   logic                      ram_wr_en;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [WORD_W-1:0]         ram_rd_data;
   logic [31:0]               wr_idx32;

   logic [PHASE_W-1:0]        cur;
   logic [LIM_W-1:0]          cur_x;
   logic [LIM_W-1:0]          mag_x;
   logic [LIM_W-1:0]          pos_sum;
   logic [LIM_W:0]            pos_d;
   logic [LIM_W:0]            neg_d;
   logic [LIM_W-1:0]          neg_w;
   logic [LIM_W-1:0]          next_x;

   logic signed [SPROD_W-1:0] shifted_full;
   logic [SHIFTED_W-1:0]      shifted;

   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic                      over_ff, over_in;
   logic                      b2_valid_ff, b2_valid_in;
   logic signed [AMP_W-1:0]   b2_amp_ff, b2_amp_in;
   logic                      b3_valid_ff, b3_valid_in;
   logic signed [SPROD_W-1:0] prod_ff, prod_in;
   logic                      out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]       sample_ff, sample_in;

   assign back_adv = !out_valid_ff || rsp_ready;
   assign in_ready = back_adv;
   assign pop      = in_valid && back_adv;
   assign pop_gen  = pop && in_item.gen;

   // table write; indexes past the depth are dropped
   assign wr_idx32    = 32'(in_item.index);
   assign ram_wr_en   = pop && !in_item.gen && (wr_idx32 < 32'(TABLE_DEPTH));
   assign ram_wr_addr = wr_idx32[ADDR_W-1:0];

   // phase restarts at zero if it sits past a shortened table
   assign cur         = over_ff ? '0 : phase_ff;
   assign ram_rd_en   = pop_gen;
   assign ram_rd_addr = cur[PHASE_W-1:PHASE_FRAC];

   tlo_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (in_item.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // wrap in either direction, both candidates in parallel
   assign cur_x   = {1'b0, cur};
   assign mag_x   = {1'b0, in_item.mag};
   assign pos_sum = cur_x + mag_x;
   assign pos_d   = {1'b0, pos_sum} - {1'b0, cfg.limit};
   assign neg_d   = {1'b0, cur_x} - {1'b0, mag_x};
   assign neg_w   = cur_x + cfg.limit - mag_x;

   always_comb begin
      if (in_item.neg) begin
         next_x = neg_d[LIM_W] ? neg_w : neg_d[LIM_W-1:0];
      end else begin
         next_x = pos_d[LIM_W] ? pos_sum : pos_d[LIM_W-1:0];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      over_in  = ({1'b0, phase_ff} >= cfg.limit);
      if (pop_gen) begin
         phase_in = next_x[PHASE_W-1:0];
         over_in  = 1'b0;
      end
   end

   always_comb begin
      b2_valid_in  = b2_valid_ff;
      b2_amp_in    = b2_amp_ff;
      b3_valid_in  = b3_valid_ff;
      prod_in      = prod_ff;
      out_valid_in = out_valid_ff;
      sample_in    = sample_ff;
      if (back_adv) begin
         b2_valid_in  = pop_gen;
         b2_amp_in    = in_item.amp;
         b3_valid_in  = b2_valid_ff;
         prod_in      = SPROD_W'(b2_amp_ff) * SPROD_W'($signed(ram_rd_data));
         out_valid_in = b3_valid_ff;
         if (shifted[SHIFTED_W-1] != shifted[SHIFTED_W-2]) begin
            sample_in = shifted[SHIFTED_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
         end else begin
            sample_in = shifted[SAMPLE_W-1:0];
         end
      end
   end

   // floor shift of the Q17.39 product back to Q16.16
   assign shifted_full = prod_ff >>> WORD_FRAC;
   assign shifted      = shifted_full[SHIFTED_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         over_ff      <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         over_ff      <= over_in;
         b2_valid_ff  <= b2_valid_in;
         b3_valid_ff  <= b3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b2_amp_ff <= b2_amp_in;
      prod_ff   <= prod_in;
      sample_ff <= sample_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = sample_ff;

   a_gen_fills_b2: assert property (@(posedge clock) disable iff (reset)
      pop_gen |=> b2_valid_ff)
      else $error("generate item lost after lookup");

   a_gen_clears_over: assert property (@(posedge clock) disable iff (reset)
      pop_gen |=> !over_ff)
      else $error("phase restart flag set after phase update");

   a_stall_holds_prod: assert property (@(posedge clock) disable iff (reset)
      (!back_adv && b3_valid_ff) |=> $stable(prod_ff))
      else $error("product changed during output stall");

   a_one_ram_op: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> !ram_wr_en)
      else $error("table read and write in the same cycle");

endmodule
